@@ design/fdr_pkg.sv @@
// Shared constants and register codes for the frame difference dirty-rectangle block.
package fdr_pkg;

  localparam int PIX_W    = 32;
  localparam int CFG_W    = 11;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;
  localparam int LEFT_W   = 10;
  localparam int RIGHT_W  = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic {
    REG_LINE_PIXELS = 1'b0,
    REG_FRAME_LINES = 1'b1
  } reg_idx_t;

endpackage

@@ design/fdr_if.sv @@
// Stream interfaces for pixel input and change-report output transactions.
interface pix_in_if import fdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface pix_out_if import fdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_out;
  logic               pixel_changed;
  logic               frame_done;
  logic               frame_changed;
  logic [LEFT_W-1:0]  rect_left;
  logic [LEFT_W-1:0]  rect_top;
  logic [RIGHT_W-1:0] rect_right;
  logic [RIGHT_W-1:0] rect_bottom;

  modport source (
    output valid, output pixel_out, output pixel_changed, output frame_done,
    output frame_changed, output rect_left, output rect_top, output rect_right,
    output rect_bottom, input ready
  );
  modport sink (
    input valid, input pixel_out, input pixel_changed, input frame_done,
    input frame_changed, input rect_left, input rect_top, input rect_right,
    input rect_bottom, output ready
  );
endinterface

@@ design/frame_diff_dirty_rect_top.sv @@
// Frame difference dirty-rectangle detector: top level with previous-frame store.
// Pipeline: an accepted pixel reads its previous-frame word into stage 1,
//   which compares and writes back as it hands on to the output register.
// Throughput: one pixel per cycle, set by the single read and single write port
//   of the previous-frame store; back-pressure on the output stalls the pipe.
// Reset (rst_n low, synchronous): control state cleared, then a clearing pass
//   zeroes all MAX_LINE_PIXELS*MAX_LINES store words, one word a cycle, during
//   which no pixel is accepted; register writes are taken throughout.
module frame_diff_dirty_rect_top import fdr_pkg::*; #(
  parameter int MAX_LINE_PIXELS = 1024,
  parameter int MAX_LINES       = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  pix_in_if.sink            in_ch,
  pix_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Widths derived from the maximum frame geometry
  localparam int DEPTH = MAX_LINE_PIXELS * MAX_LINES;
  localparam int CW    = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
  localparam int RW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LPW   = $clog2(MAX_LINE_PIXELS + 1);
  localparam int FLW   = $clog2(MAX_LINES + 1);
  localparam int MW0   = (LPW > FLW) ? LPW : FLW;
  localparam int CMPW  = ((MW0 > CFG_W) ? MW0 : CFG_W) + 1;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] line_pixels_r;
  logic [CFG_W-1:0] frame_lines_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pixels_r <= CFG_RESET;
      frame_lines_r <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_LINE_PIXELS: line_pixels_r <= pwdata[CFG_W-1:0];
        REG_FRAME_LINES: frame_lines_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_LINE_PIXELS: prdata = APB_DW'(line_pixels_r);
      REG_FRAME_LINES: prdata = APB_DW'(frame_lines_r);
      default:         prdata = '0;
    endcase
  end

  // Effective geometry: zero acts as one, values above the maximum saturate
  logic [CMPW-1:0] lp_raw, fl_raw, lp_eff, fl_eff;

  always_comb begin
    lp_raw = CMPW'(line_pixels_r);
    fl_raw = CMPW'(frame_lines_r);
    if (lp_raw == '0) begin
      lp_eff = CMPW'(1);
    end else if (lp_raw > CMPW'(MAX_LINE_PIXELS)) begin
      lp_eff = CMPW'(MAX_LINE_PIXELS);
    end else begin
      lp_eff = lp_raw;
    end
    if (fl_raw == '0) begin
      fl_eff = CMPW'(1);
    end else if (fl_raw > CMPW'(MAX_LINES)) begin
      fl_eff = CMPW'(MAX_LINES);
    end else begin
      fl_eff = fl_raw;
    end
  end

  // ---------------------------------------------------------------------
  // Store clearing pass after reset
  // ---------------------------------------------------------------------
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic out_can;   // output register free, or being emptied this cycle
  logic s1_go;     // stage 1 hands its result to the output register
  logic accept;

  assign out_can     = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && out_can;
  assign in_ch.ready = !clr_busy_r && (!s1_valid_r || out_can);
  assign accept      = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------
  // Stage 0: raster position and store address
  // ---------------------------------------------------------------------
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] row_base_r;
  logic          line_end;
  logic          frame_end;

  assign line_end  = (CMPW'(col_r) + CMPW'(1)) >= lp_eff;
  assign frame_end = line_end && ((CMPW'(row_r) + CMPW'(1)) >= fl_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      addr_r     <= '0;
      row_base_r <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col_r      <= '0;
        row_r      <= '0;
        addr_r     <= '0;
        row_base_r <= '0;
      end else if (line_end) begin
        // next row starts one full stride on, whatever the line length
        col_r      <= '0;
        row_r      <= row_r + RW'(1);
        addr_r     <= row_base_r + AW'(MAX_LINE_PIXELS);
        row_base_r <= row_base_r + AW'(MAX_LINE_PIXELS);
      end else begin
        col_r  <= col_r + CW'(1);
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Previous-frame store: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [PIX_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: compare, write back, extents
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0] s1_pix_r;
  logic [AW-1:0]    s1_addr_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic             s1_fend_r;
  logic             s1_fwd_r;       // read raced a write to the same word
  logic [PIX_W-1:0] s1_fwd_data_r;

  logic [PIX_W-1:0] prev_word;
  logic             changed;

  assign prev_word = s1_fwd_r ? s1_fwd_data_r : rd_data_r;
  assign changed   = prev_word != s1_pix_r;

  assign mem_we    = clr_busy_r || (s1_go && changed);
  assign mem_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clr_busy_r ? '0 : s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= in_ch.pixel_in;
      s1_addr_r     <= addr_r;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_fend_r     <= frame_end;
      // only a one-pixel frame revisits a word in the very next transaction
      s1_fwd_r      <= s1_go && changed && (s1_addr_r == addr_r);
      s1_fwd_data_r <= s1_pix_r;
    end
  end

  // Extent tracking
  logic          any_change_r;
  logic [CW-1:0] min_col_r, max_col_r;
  logic [RW-1:0] min_row_r, max_row_r;
  logic [CW-1:0] min_col_nxt, max_col_nxt;
  logic [RW-1:0] min_row_nxt, max_row_nxt;
  logic          any_change_nxt;

  always_comb begin
    min_col_nxt    = min_col_r;
    max_col_nxt    = max_col_r;
    min_row_nxt    = min_row_r;
    max_row_nxt    = max_row_r;
    any_change_nxt = any_change_r || changed;
    if (changed) begin
      if (!any_change_r) begin
        min_col_nxt = s1_col_r;
        max_col_nxt = s1_col_r;
        min_row_nxt = s1_row_r;
        max_row_nxt = s1_row_r;
      end else begin
        if (s1_col_r < min_col_r) min_col_nxt = s1_col_r;
        if (s1_col_r > max_col_r) max_col_nxt = s1_col_r;
        if (s1_row_r < min_row_r) min_row_nxt = s1_row_r;
        if (s1_row_r > max_row_r) max_row_nxt = s1_row_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_change_r <= 1'b0;
    end else if (s1_go) begin
      any_change_r <= s1_fend_r ? 1'b0 : any_change_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      min_col_r <= min_col_nxt;
      max_col_r <= max_col_nxt;
      min_row_r <= min_row_nxt;
      max_row_r <= max_row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic               frame_chg;
  logic [CW:0]        right_w;
  logic [RW:0]        bottom_w;

  assign frame_chg = s1_fend_r && any_change_nxt;
  assign right_w   = {1'b0, max_col_nxt} + (CW+1)'(1);
  assign bottom_w  = {1'b0, max_row_nxt} + (RW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_ch.pixel_out     <= changed ? s1_pix_r : '0;
      out_ch.pixel_changed <= changed;
      out_ch.frame_done    <= s1_fend_r;
      out_ch.frame_changed <= frame_chg;
      out_ch.rect_left     <= frame_chg ? LEFT_W'(min_col_nxt) : '0;
      out_ch.rect_top      <= frame_chg ? LEFT_W'(min_row_nxt) : '0;
      out_ch.rect_right    <= frame_chg ? RIGHT_W'(right_w) : '0;
      out_ch.rect_bottom   <= frame_chg ? RIGHT_W'(bottom_w) : '0;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

@@ design/fdr_checker.sv @@
// Port-level assertions for the dirty-rectangle top level, with its bind.
module fdr_checker import fdr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PIX_W-1:0]   pixel_out,
  input logic               pixel_changed,
  input logic               frame_done,
  input logic               frame_changed,
  input logic [LEFT_W-1:0]  rect_left,
  input logic [LEFT_W-1:0]  rect_top,
  input logic [RIGHT_W-1:0] rect_right,
  input logic [RIGHT_W-1:0] rect_bottom
);

  // stalled result keeps its pixel_out, frame_done and rect_right
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_done)
      && $stable(rect_right))
    else $error("result changed while stalled");

  a_chg_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_changed |-> frame_done)
    else $error("frame_changed outside frame end");

  a_rect_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_changed |-> rect_left == '0 && rect_top == '0
      && rect_right == '0 && rect_bottom == '0)
    else $error("rectangle reported without change");

  a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pixel_changed |-> pixel_out == '0)
    else $error("unchanged pixel carries data");

endmodule

bind frame_diff_dirty_rect_top fdr_checker u_fdr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .pixel_out     (out_ch.pixel_out),
  .pixel_changed (out_ch.pixel_changed),
  .frame_done    (out_ch.frame_done),
  .frame_changed (out_ch.frame_changed),
  .rect_left     (out_ch.rect_left),
  .rect_top      (out_ch.rect_top),
  .rect_right    (out_ch.rect_right),
  .rect_bottom   (out_ch.rect_bottom)
);

@@ tb/sv/fdr_checker.sv @@
// Change-report predictor and scoreboard for the frame difference dirty-rectangle block.
`timescale 1ns / 100ps
module fdr_scoreboard import fdr_pkg::*; #(
  parameter int MAX_LINE_PIXELS = 1024,
  parameter int MAX_LINES       = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  pix_in_if                 in_ch,
  pix_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic               chg;
    logic               done;
    logic               fchg;
    logic [LEFT_W-1:0]  left;
    logic [LEFT_W-1:0]  top;
    logic [RIGHT_W-1:0] right;
    logic [RIGHT_W-1:0] bottom;
  } report_t;

  report_t          expected_reports[$];
  report_t          want;
  int               fails = 0;
  int               depth = 0;

  // mirrored block state
  logic [PIX_W-1:0] prev_frame [int unsigned];
  int unsigned      col_cnt, row_cnt;
  int unsigned      min_col, min_row, max_col, max_row;
  bit               any_chg;
  logic [CFG_W-1:0] line_reg, lines_reg;

  assign fail_count = fails;
  assign pending    = depth;

  function automatic int unsigned eff_size(logic [CFG_W-1:0] raw, int unsigned cap);
    if (raw == '0) return 1;
    if (raw > cap) return cap;
    return raw;
  endfunction

  function automatic report_t diff_pixel(logic [PIX_W-1:0] px);
    report_t     r;
    int unsigned lp, fl, adr;
    bit          chg, line_end, frame_end;
    logic [PIX_W-1:0] old;
    r   = '0;
    chg = 1'b0;
    lp  = eff_size(line_reg, MAX_LINE_PIXELS);
    fl  = eff_size(lines_reg, MAX_LINES);
    adr = row_cnt * MAX_LINE_PIXELS + col_cnt;
    if (col_cnt < MAX_LINE_PIXELS && adr < MAX_LINE_PIXELS * MAX_LINES) begin
      old = prev_frame.exists(adr) ? prev_frame[adr] : '0;
      if (old != px) begin
        prev_frame[adr] = px;
        chg = 1'b1;
      end
    end
    if (chg) begin
      if (!any_chg) begin
        min_col = col_cnt; max_col = col_cnt;
        min_row = row_cnt; max_row = row_cnt;
      end else begin
        if (col_cnt < min_col) min_col = col_cnt;
        if (col_cnt > max_col) max_col = col_cnt;
        if (row_cnt < min_row) min_row = row_cnt;
        if (row_cnt > max_row) max_row = row_cnt;
      end
      any_chg = 1'b1;
    end
    line_end  = (col_cnt + 1 >= lp);
    frame_end = line_end && (row_cnt + 1 >= fl);
    r.pix  = chg ? px : '0;
    r.chg  = chg;
    r.done = frame_end;
    if (frame_end && any_chg) begin
      r.fchg   = 1'b1;
      r.left   = LEFT_W'(min_col);
      r.top    = LEFT_W'(min_row);
      r.right  = RIGHT_W'(max_col + 1);
      r.bottom = RIGHT_W'(max_row + 1);
    end
    if (frame_end) begin
      col_cnt = 0; row_cnt = 0; any_chg = 1'b0;
      min_col = 0; min_row = 0; max_col = 0; max_row = 0;
    end else if (line_end) begin
      col_cnt = 0;
      row_cnt = row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [PIX_W-1:0] exp_v,
                                      logic [PIX_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected %0h got %0h", name, exp_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      prev_frame.delete();
      expected_reports.delete();
      col_cnt = 0; row_cnt = 0; any_chg = 1'b0;
      min_col = 0; min_row = 0; max_col = 0; max_row = 0;
      line_reg  = CFG_RESET;
      lines_reg = CFG_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_LINE_PIXELS: line_reg  = pwdata[CFG_W-1:0];
          REG_FRAME_LINES: lines_reg = pwdata[CFG_W-1:0];
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_reports.push_back(diff_pixel(in_ch.pixel_in));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction with no pixel outstanding");
          fails++;
        end else begin
          want = expected_reports.pop_front();
          check_field("pixel_out", want.pix, out_ch.pixel_out);
          check_field("pixel_changed", PIX_W'(want.chg), PIX_W'(out_ch.pixel_changed));
          check_field("frame_done", PIX_W'(want.done), PIX_W'(out_ch.frame_done));
          check_field("frame_changed", PIX_W'(want.fchg), PIX_W'(out_ch.frame_changed));
          check_field("rect_left", PIX_W'(want.left), PIX_W'(out_ch.rect_left));
          check_field("rect_top", PIX_W'(want.top), PIX_W'(out_ch.rect_top));
          check_field("rect_right", PIX_W'(want.right), PIX_W'(out_ch.rect_right));
          check_field("rect_bottom", PIX_W'(want.bottom), PIX_W'(out_ch.rect_bottom));
        end
      end
    end
    depth = expected_reports.size();
  end

endmodule

@@ tb/sv/tb_frame_diff_dirty_rect_top.sv @@
// Testbench top: pixel stimulus, register programming and verdict for the dirty-rectangle block.
`timescale 1ns / 100ps
module tb_frame_diff_dirty_rect_top;
  import fdr_pkg::*;

  localparam int MAX_LP     = 1024;
  localparam int MAX_FL     = 1024;
  localparam int LONG_HOLD  = 400;        // cycles the sink sits on ready once
  localparam int RAND_ITEMS = 300;        // random pixels with idling
  localparam int TAIL_ITEMS = 100;        // closing pixels at full rate

  typedef enum {FR_STATIC, FR_SPOT, FR_RECT, FR_NOISE} frame_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int                fail_count;
  int                pending;

  // stimulus-side bookkeeping
  int unsigned       cur_lp, cur_fl;      // effective geometry last programmed
  int                sent_items = 0;
  bit                idle_on    = 1'b1;   // random gaps on both sides
  bit                hold_req   = 1'b0;   // asks the sink for its one long hold-off
  logic [PIX_W-1:0]  last_sent [int unsigned];  // last word sent per store address

  pix_in_if  in_ch ();
  pix_out_if out_ch ();

  frame_diff_dirty_rect_top #(
    .MAX_LINE_PIXELS(MAX_LP),
    .MAX_LINES      (MAX_FL)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  fdr_scoreboard #(
    .MAX_LINE_PIXELS(MAX_LP),
    .MAX_LINES      (MAX_FL)
  ) CHK (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop, with room for the store-clearing pass over all MAX_LP*MAX_FL words after reset.
  initial begin
    #(40_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // Result sink: short random stalls, plus a single long hold-off on request so the
  // pipe backs up and the input side has to stall.
  initial begin : sink_side
    int  n;
    bit  hold_taken;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Register value as the block interprets it: zero acts as one, big values saturate.
  function automatic int unsigned eff_size(logic [CFG_W-1:0] raw, int unsigned cap);
    if (raw == '0) return 1;
    if (raw > cap) return cap;
    return raw;
  endfunction

  // Corner-heavy pixel words: all zero, all one, walking one/zero, or anything.
  function automatic logic [PIX_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'(1) << $urandom_range(0, PIX_W - 1);
      3:       return ~(PIX_W'(1) << $urandom_range(0, PIX_W - 1));
      default: return $urandom();
    endcase
  endfunction

  // Always differs from old.
  function automatic logic [PIX_W-1:0] changed_word(logic [PIX_W-1:0] old);
    logic [PIX_W-1:0] w;
    w = old ^ rand_word();
    if (w == old) w = ~old;
    return w;
  endfunction

  function automatic frame_mode_t pick_mode();
    case ($urandom_range(0, 9))
      0, 1:       return FR_STATIC;
      2, 3:       return FR_SPOT;
      4, 5, 6, 7: return FR_RECT;
      default:    return FR_NOISE;
    endcase
  endfunction

  // One pixel transaction. valid stays high after acceptance so back-to-back
  // transactions never see valid dropped and raised in the same step.
  task automatic push_pixel(input logic [PIX_W-1:0] px);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.pixel_in <= px;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic send_word(input int unsigned adr, input logic [PIX_W-1:0] px);
    push_pixel(px);
    last_sent[adr] = px;
  endtask

  // Repeat the last word at this address, or send one that surely differs.
  task automatic send_shadowed(input int unsigned adr, input bit flip);
    logic [PIX_W-1:0] old;
    old = last_sent.exists(adr) ? last_sent[adr] : '0;
    send_word(adr, flip ? changed_word(old) : old);
  endtask

  // Let the pipe drain before touching registers. The first edge makes sure the
  // checker has seen the last accepted pixel.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup then access; upper data bits are junk the block must drop.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] word;
    word = $urandom();
    word[CFG_W-1:0] = val;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(input int lp_raw, input int fl_raw);
    settle();
    write_reg(REG_LINE_PIXELS, CFG_W'(lp_raw));
    write_reg(REG_FRAME_LINES, CFG_W'(fl_raw));
    cur_lp = eff_size(CFG_W'(lp_raw), MAX_LP);
    cur_fl = eff_size(CFG_W'(fl_raw), MAX_FL);
  endtask

  // One whole frame from the top-left corner. Static repeats the last frame, spot
  // changes a single pixel, rect changes most of a random sub-rectangle, noise
  // changes about half of the frame with its first and last pixels always hit.
  task automatic send_frame(input frame_mode_t mode, input int spot = -1);
    int          x0, x1, y0, y1, sp, idx, last_idx;
    bit          flip;
    x0 = $urandom_range(0, cur_lp - 1);
    x1 = $urandom_range(x0, cur_lp - 1);
    y0 = $urandom_range(0, cur_fl - 1);
    y1 = $urandom_range(y0, cur_fl - 1);
    last_idx = cur_lp * cur_fl - 1;
    sp = (spot < 0) ? $urandom_range(0, last_idx) : spot;
    for (int r = 0; r < cur_fl; r++) begin
      for (int c = 0; c < cur_lp; c++) begin
        idx = r * cur_lp + c;
        case (mode)
          FR_STATIC: flip = 1'b0;
          FR_SPOT:   flip = (idx == sp);
          FR_RECT:   flip = (c >= x0 && c <= x1 && r >= y0 && r <= y1 &&
                             $urandom_range(0, 3) != 0);
          default:   flip = (idx == 0 || idx == last_idx || $urandom_range(0, 1) == 1);
        endcase
        send_shadowed(r * MAX_LP + c, flip);
      end
    end
  endtask

  // Stop part-way through a frame, shrink both registers to at most one past the current
  // position while the counters sit there, and check that the next pixel closes the frame.
  task automatic partial_then_shrink();
    int k, pc, pr;
    set_geometry($urandom_range(2, 4), $urandom_range(2, 4));
    k = $urandom_range(1, cur_lp * cur_fl - 1);
    for (int i = 0; i < k; i++)
      send_shadowed((i / cur_lp) * MAX_LP + (i % cur_lp), $urandom_range(0, 1));
    pc = k % cur_lp;
    pr = k / cur_lp;
    // zero is allowed here and must behave as one
    set_geometry($urandom_range(0, pc + 1), $urandom_range(0, pr + 1));
    send_shadowed(pr * MAX_LP + pc, $urandom_range(0, 1));
  endtask

  // Saturating register values: n pixels into a frame that must not end early,
  // then both registers are written zero, which acts as one, so the next pixel closes the frame.
  task automatic saturated_run(input int lp_raw, input int fl_raw, input int n,
                               input bit hold);
    int pc, pr;
    set_geometry(lp_raw, fl_raw);
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < n; i++)
      send_shadowed((i / cur_lp) * MAX_LP + (i % cur_lp), $urandom_range(0, 1));
    pc = n % cur_lp;
    pr = n / cur_lp;
    set_geometry(0, 0);
    send_shadowed(pr * MAX_LP + pc, 1'b1);
  endtask

  // A burst of small frames, now and then odd register values.
  task automatic small_phase();
    int lp_raw, fl_raw;
    if ($urandom_range(0, 7) == 0) begin
      partial_then_shrink();
    end else begin
      lp_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      fl_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      set_geometry(lp_raw, fl_raw);
      repeat ($urandom_range(1, 4)) send_frame(pick_mode());
    end
  endtask

  initial begin : stimulus
    int target;
    in_ch.valid    <= 1'b0;
    in_ch.pixel_in <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    rst_n          <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single-pixel frames with an unchanged pixel against the cleared
    // store, all-ones over zero, a repeat, back to zero.
    set_geometry(1, 1);
    send_word(0, '0);
    send_word(0, '1);
    send_word(0, '1);
    send_word(0, '0);
    // zero-valued registers act as one
    set_geometry(0, 0);
    send_word(0, 32'h8000_0001);
    set_geometry(3, 2);
    send_frame(FR_NOISE);
    partial_then_shrink();

    // Wide line via a saturating register value; the sink stalls for a long
    // stretch at the start so the block fills and pushes back on the input.
    saturated_run(2047, 1, 120, 1'b1);
    // Tall frame, also saturated, run down the first column.
    saturated_run(1, 1500, 60, 1'b0);

    // Random small frames with idling on both sides.
    target = sent_items + RAND_ITEMS;
    while (sent_items < target) small_phase();

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    target  = sent_items + TAIL_ITEMS;
    while (sent_items < target) small_phase();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
